FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 71;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  // internal row can reach ROWS after a newline on the last row
  localparam int ROWR_W = $clog2(ROWS + 1);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int PC_W   = 5;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
  localparam logic [COL_W-1:0]  TAB_MASK = 7'd7;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_line;
  } tcw_out_t;

  typedef enum logic [3:0] {
    ACT_NOP       = 4'd0,
    ACT_ACCEPT    = 4'd1,
    ACT_CLEAR     = 4'd2,
    ACT_CAPTURE   = 4'd3,
    ACT_EMIT      = 4'd4,
    ACT_WRITE     = 4'd5,
    ACT_NEWLINE   = 4'd6,
    ACT_SCR_START = 4'd7,
    ACT_SCR_STEP  = 4'd8,
    ACT_SCR_END   = 4'd9
  } act_e;

  typedef enum logic [3:0] {
    COND_NEVER      = 4'd0,
    COND_ALWAYS     = 4'd1,
    COND_NO_IN      = 4'd2,
    COND_OUT_BUSY   = 4'd3,
    COND_IS_READ    = 4'd4,
    COND_IS_ZERO    = 4'd5,
    COND_IS_NL      = 4'd6,
    COND_ROW_OVER   = 4'd7,
    COND_NO_OVER    = 4'd8,
    COND_TAB_MORE   = 4'd9,
    COND_SWEEP_MORE = 4'd10
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic no_in;
    logic out_busy;
    logic is_read;
    logic is_zero;
    logic is_nl;
    logic row_over;
    logic tab_more;
    logic sweep_more;
  } flags_t;

  localparam pc_t ST_CLEAR     = 5'd0;
  localparam pc_t ST_TO_IDLE   = 5'd1;
  localparam pc_t ST_CAPTURE   = 5'd2;
  localparam pc_t ST_EMIT      = 5'd3;
  localparam pc_t ST_IDLE      = 5'd4;
  localparam pc_t ST_DISP_RD   = 5'd5;
  localparam pc_t ST_DISP_ZERO = 5'd6;
  localparam pc_t ST_DISP_NL   = 5'd7;
  localparam pc_t ST_PUT_CHK   = 5'd8;
  localparam pc_t ST_WRITE     = 5'd9;
  localparam pc_t ST_PUT_DONE  = 5'd10;
  localparam pc_t ST_NL        = 5'd11;
  localparam pc_t ST_NL_CHK    = 5'd12;
  localparam pc_t ST_SCR_START = 5'd13;
  localparam pc_t ST_SCR_STEP  = 5'd14;
  localparam pc_t ST_SCR_END   = 5'd15;
  localparam pc_t ST_SCR_RET   = 5'd16;

  // microprogram: action, jump condition, jump target; fall through otherwise
  function automatic ctl_t ucode(pc_t pc);
    ctl_t w;
    case (pc)
      ST_CLEAR:     w = '{ACT_CLEAR,     COND_SWEEP_MORE, ST_CLEAR};
      ST_TO_IDLE:   w = '{ACT_NOP,       COND_ALWAYS,     ST_IDLE};
      ST_CAPTURE:   w = '{ACT_CAPTURE,   COND_NEVER,      ST_EMIT};
      ST_EMIT:      w = '{ACT_EMIT,      COND_OUT_BUSY,   ST_EMIT};
      ST_IDLE:      w = '{ACT_ACCEPT,    COND_NO_IN,      ST_IDLE};
      ST_DISP_RD:   w = '{ACT_NOP,       COND_IS_READ,    ST_CAPTURE};
      ST_DISP_ZERO: w = '{ACT_NOP,       COND_IS_ZERO,    ST_EMIT};
      ST_DISP_NL:   w = '{ACT_NOP,       COND_IS_NL,      ST_NL};
      ST_PUT_CHK:   w = '{ACT_NOP,       COND_ROW_OVER,   ST_SCR_START};
      ST_WRITE:     w = '{ACT_WRITE,     COND_TAB_MORE,   ST_PUT_CHK};
      ST_PUT_DONE:  w = '{ACT_NOP,       COND_ALWAYS,     ST_EMIT};
      ST_NL:        w = '{ACT_NEWLINE,   COND_NEVER,      ST_NL_CHK};
      ST_NL_CHK:    w = '{ACT_NOP,       COND_NO_OVER,    ST_EMIT};
      ST_SCR_START: w = '{ACT_SCR_START, COND_NEVER,      ST_SCR_STEP};
      ST_SCR_STEP:  w = '{ACT_SCR_STEP,  COND_SWEEP_MORE, ST_SCR_STEP};
      ST_SCR_END:   w = '{ACT_SCR_END,   COND_IS_NL,      ST_NL_CHK};
      ST_SCR_RET:   w = '{ACT_NOP,       COND_ALWAYS,     ST_PUT_CHK};
      default:      w = '{ACT_NOP,       COND_ALWAYS,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/tcw_seq.sv
module tcw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcw_pkg::flags_t flags_i,
  output tcw_pkg::ctl_t   ctl_o
);

  tcw_pkg::pc_t  pc_q, pc_d;
  tcw_pkg::ctl_t word;
  logic          taken;

  assign word  = tcw_pkg::ucode(pc_q);
  assign ctl_o = word;

  always_comb begin
    case (word.cond)
      tcw_pkg::COND_NEVER:      taken = 1'b0;
      tcw_pkg::COND_ALWAYS:     taken = 1'b1;
      tcw_pkg::COND_NO_IN:      taken = flags_i.no_in;
      tcw_pkg::COND_OUT_BUSY:   taken = flags_i.out_busy;
      tcw_pkg::COND_IS_READ:    taken = flags_i.is_read;
      tcw_pkg::COND_IS_ZERO:    taken = flags_i.is_zero;
      tcw_pkg::COND_IS_NL:      taken = flags_i.is_nl;
      tcw_pkg::COND_ROW_OVER:   taken = flags_i.row_over;
      tcw_pkg::COND_NO_OVER:    taken = ~flags_i.row_over;
      tcw_pkg::COND_TAB_MORE:   taken = flags_i.tab_more;
      tcw_pkg::COND_SWEEP_MORE: taken = flags_i.sweep_more;
      default:                  taken = 1'b1;
    endcase
    pc_d = taken ? word.target : pc_q + tcw_pkg::pc_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= tcw_pkg::ST_CLEAR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: hw/rtl/text_console_writer.sv
// A read captures the addressed cell and a zero character does nothing before the result;
// a put writes one cell (spaces up to the next tab stop for a tab), a newline moves down.
// A scroll of the store (after a newline, or before a put, that finds the cursor past row
// ROWS-2) copies rows 1..ROWS-1 up one row: one cell is copied per cycle.
// One word at a time; the next is taken in the cycle after the result register loads.
// Reset clears all 2272 cells, one per cycle; ready first rises once that sweep ends.
module text_console_writer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int RW = tcw_pkg::ROWR_W;
  localparam int CW = tcw_pkg::COL_W;
  localparam int DW = tcw_pkg::CHAR_W;

  localparam logic [AW-1:0] COLS_A    = AW'(tcw_pkg::COLS);
  localparam logic [AW-1:0] LAST_A    = AW'(tcw_pkg::CELLS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(tcw_pkg::COLS - 1);
  localparam logic [RW-1:0] SCR_ROW   = RW'(tcw_pkg::ROWS - 2);

  tcw_pkg::ctl_t     ctl;
  tcw_pkg::flags_t   flags;
  tcw_pkg::tcw_out_t out_q;

  logic [DW-1:0] mem [tcw_pkg::CELLS];

  logic [CW-1:0] col_q, col_d, col_adv;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] src_q, src_d;
  logic          cp_pend_q;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] wa_q, req_addr_q, cur_addr, mem_raddr, mem_waddr;
  logic [DW-1:0] char_q, cell_q, rdata_q, mem_wdata, char_s;
  logic          is_read_q, is_zero_q, is_nl_q, is_tab_q, rd_ok_q;
  logic          mem_we, wrap, accept, emit_go, out_busy, rd_ok;
  logic [AW-1:0] rd_addr;

  tcw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  assign in_ready_o = (ctl.act == tcw_pkg::ACT_ACCEPT);
  assign accept     = in_ready_o & in_valid_i;
  assign out_busy   = out_valid_q & ~out_ready_i;
  assign emit_go    = (ctl.act == tcw_pkg::ACT_EMIT) & ~out_busy;

  assign wrap     = (col_q == LAST_COL);
  assign col_adv  = wrap ? '0 : col_q + CW'(1);
  assign cur_addr = AW'(row_q) * COLS_A + AW'(col_q);

  assign rd_ok   = (32'(in_data_i.read_row) < tcw_pkg::ROWS) &&
                   (32'(in_data_i.read_col) < tcw_pkg::COLS);
  assign rd_addr = rd_ok ? AW'(in_data_i.read_row) * COLS_A + AW'(in_data_i.read_col) : '0;

  // map tab to space, unprintable codes to '?'
  always_comb begin
    if (in_data_i.char_code == tcw_pkg::CH_TAB) begin
      char_s = tcw_pkg::CH_SPACE;
    end else if (in_data_i.char_code < tcw_pkg::CH_SPACE ||
                 in_data_i.char_code > tcw_pkg::CH_TILDE) begin
      char_s = tcw_pkg::CH_QMARK;
    end else begin
      char_s = in_data_i.char_code;
    end
  end

  always_comb begin
    flags.no_in      = ~in_valid_i;
    flags.out_busy   = out_busy;
    flags.is_read    = is_read_q;
    flags.is_zero    = is_zero_q;
    flags.is_nl      = is_nl_q;
    flags.row_over   = (row_q > SCR_ROW);
    flags.tab_more   = is_tab_q & ((col_adv & tcw_pkg::TAB_MASK) != '0);
    flags.sweep_more = (src_q != LAST_A);
  end

  // store ports: a pending scroll copy owns the write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = char_q;
    if (cp_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wa_q;
      mem_wdata = rdata_q;
    end else if (ctl.act == tcw_pkg::ACT_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = src_q;
      mem_wdata = '0;
    end else if (ctl.act == tcw_pkg::ACT_WRITE) begin
      mem_we    = 1'b1;
    end
    mem_raddr = (ctl.act == tcw_pkg::ACT_SCR_STEP) ? src_q : req_addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    src_d = src_q;
    case (ctl.act)
      tcw_pkg::ACT_WRITE: begin
        col_d = col_adv;
        if (wrap) begin
          row_d = row_q + RW'(1);
        end
      end
      tcw_pkg::ACT_NEWLINE: begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end
      tcw_pkg::ACT_SCR_END:   row_d = row_q - RW'(1);
      tcw_pkg::ACT_CLEAR:     src_d = src_q + AW'(1);
      tcw_pkg::ACT_SCR_START: src_d = COLS_A;
      tcw_pkg::ACT_SCR_STEP:  src_d = src_q + AW'(1);
      default: ;
    endcase
    out_valid_d = emit_go | out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      src_q       <= '0;
      cp_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      src_q       <= src_d;
      cp_pend_q   <= (ctl.act == tcw_pkg::ACT_SCR_STEP);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.act == tcw_pkg::ACT_SCR_STEP) begin
      wa_q <= src_q - COLS_A;
    end
    if (accept) begin
      is_read_q  <= in_data_i.operation;
      is_zero_q  <= (in_data_i.char_code == tcw_pkg::CH_NUL);
      is_nl_q    <= (in_data_i.char_code == tcw_pkg::CH_NL);
      is_tab_q   <= (in_data_i.char_code == tcw_pkg::CH_TAB);
      char_q     <= char_s;
      rd_ok_q    <= rd_ok;
      req_addr_q <= rd_addr;
      cell_q     <= '0;
    end else if (ctl.act == tcw_pkg::ACT_CAPTURE) begin
      cell_q <= rd_ok_q ? rdata_q : '0;
    end
    if (emit_go) begin
      out_q.cell_char     <= cell_q;
      out_q.cursor_column <= col_q;
      out_q.cursor_line   <= row_q[tcw_pkg::ROW_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_pend_q |-> (ctl.act != tcw_pkg::ACT_WRITE) && (ctl.act != tcw_pkg::ACT_CLEAR))
    else $error("scroll copy collides with another store write");

  a_write_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.act == tcw_pkg::ACT_WRITE) |-> (row_q <= SCR_ROW) && (col_q <= LAST_COL))
    else $error("character written outside the visible rows");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second word taken while one is at work");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |-> (row_q < RW'(tcw_pkg::ROWS)) && (col_q <= LAST_COL))
    else $error("cursor out of range at result");

endmodule

FILE: test/tb_text_console_writer.sv
module tb_text_console_writer;

  localparam logic            OP_PUT      = 1'b0;
  localparam logic            OP_READ     = 1'b1;
  localparam int unsigned     N_RANDOM    = 1725;
  localparam int unsigned     HOLD_CYCLES = 400;
  localparam int unsigned     DRAIN_TAIL  = 32;
  localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

  // Shadow copy of the console: character store, cursor, and the cursor
  // reports still owed by the block.
  class console_shadow;
    logic [tcw_pkg::CHAR_W-1:0] cells [tcw_pkg::ROWS][tcw_pkg::COLS];
    int unsigned                col;
    int unsigned                row;
    tcw_pkg::tcw_out_t          report_q[$];
    int unsigned                mismatches;
    int unsigned                puts;
    int unsigned                reads;
    int unsigned                tabs;
    int unsigned                scrolls;

    function new();
      foreach (cells[r, c]) cells[r][c] = '0;
      col        = 0;
      row        = 0;
      mismatches = 0;
      puts       = 0;
      reads      = 0;
      tabs       = 0;
      scrolls    = 0;
    endfunction

    // scroll up by however far the cursor row ran past the second-to-last row
    function void scroll_if_past_end();
      int unsigned excess;
      if (row > tcw_pkg::ROWS - 2) begin
        excess = row - (tcw_pkg::ROWS - 2);
        for (int n = 0; n < excess; n++) begin
          for (int r = 0; r < tcw_pkg::ROWS - 1; r++)
            for (int c = 0; c < tcw_pkg::COLS; c++) cells[r][c] = cells[r + 1][c];
          scrolls++;
        end
        row = tcw_pkg::ROWS - 2;
      end
    endfunction

    function void store_char(logic [tcw_pkg::CHAR_W-1:0] ch);
      logic [tcw_pkg::CHAR_W-1:0] shown;
      scroll_if_past_end();
      shown = (ch < tcw_pkg::CH_SPACE || ch > tcw_pkg::CH_TILDE) ? tcw_pkg::CH_QMARK : ch;
      if (row < tcw_pkg::ROWS && col < tcw_pkg::COLS) cells[row][col] = shown;
      col++;
      if (col >= tcw_pkg::COLS) begin
        col = 0;
        row++;
      end
    endfunction

    function void note_word(tcw_pkg::tcw_in_t w);
      tcw_pkg::tcw_out_t rep;
      rep.cell_char = '0;
      if (w.operation == OP_PUT) begin
        puts++;
        if (w.char_code == tcw_pkg::CH_TAB) begin
          tabs++;
          // a wrap to column 0 also ends the run of spaces
          do store_char(tcw_pkg::CH_SPACE); while ((col & tcw_pkg::TAB_MASK) != 0);
        end else if (w.char_code == tcw_pkg::CH_NL) begin
          col = 0;
          row++;
          scroll_if_past_end();
        end else if (w.char_code != tcw_pkg::CH_NUL) begin
          store_char(w.char_code);
        end
      end else begin
        reads++;
        if (w.read_row < tcw_pkg::ROWS && w.read_col < tcw_pkg::COLS)
          rep.cell_char = cells[w.read_row][w.read_col];
      end
      rep.cursor_column = tcw_pkg::COL_W'(col);
      rep.cursor_line   = tcw_pkg::ROW_W'(row);
      report_q.push_back(rep);
    endfunction

    function void check_report(tcw_pkg::tcw_out_t got);
      tcw_pkg::tcw_out_t want;
      if (report_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: char %02h col %0d line %0d",
                   got.cell_char, got.cursor_column, got.cursor_line);
        mismatches++;
        return;
      end
      want = report_q.pop_front();
      if (got.cell_char !== want.cell_char || got.cursor_column !== want.cursor_column ||
          got.cursor_line !== want.cursor_line) begin
        if (mismatches < 10)
          $display("mismatch: expected char %02h col %0d line %0d, got char %02h col %0d line %0d",
                   want.cell_char, want.cursor_column, want.cursor_line,
                   got.cell_char, got.cursor_column, got.cursor_line);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return report_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  tcw_pkg::tcw_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  tcw_pkg::tcw_out_t out_data_o;

  bit              steady   = 1'b0;
  bit              hold_req = 1'b0;
  longint unsigned cycles   = 0;
  console_shadow   shadow;

  text_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, shadow.pending());
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) shadow.check_report(out_data_o);
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  function automatic tcw_pkg::tcw_in_t put_word(logic [tcw_pkg::CHAR_W-1:0] ch);
    tcw_pkg::tcw_in_t w;
    w.operation = OP_PUT;
    w.char_code = ch;
    w.read_row  = tcw_pkg::ROW_W'($urandom);
    w.read_col  = tcw_pkg::COL_W'($urandom);
    return w;
  endfunction

  function automatic tcw_pkg::tcw_in_t read_word(int unsigned r, int unsigned c);
    tcw_pkg::tcw_in_t w;
    w.operation = OP_READ;
    w.char_code = tcw_pkg::CHAR_W'($urandom);
    w.read_row  = tcw_pkg::ROW_W'(r);
    w.read_col  = tcw_pkg::COL_W'(c);
    return w;
  endfunction

  function automatic logic [tcw_pkg::CHAR_W-1:0] pick_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3)  return tcw_pkg::CH_NUL;
    if (p < 9)  return tcw_pkg::CH_TAB;
    if (p < 17) return tcw_pkg::CH_NL;
    if (p < 21) return tcw_pkg::CHAR_W'($urandom_range(31, 1));
    if (p < 25) return tcw_pkg::CHAR_W'($urandom_range(255, 127));
    return tcw_pkg::CHAR_W'($urandom_range(126, 32));
  endfunction

  // reads lean toward the rows at and just above the cursor, where the text is
  function automatic tcw_pkg::tcw_in_t random_read();
    int unsigned p;
    int unsigned r;
    int unsigned c;
    p = $urandom_range(99);
    if (p < 50) r = $urandom_range(shadow.row, (shadow.row >= 3) ? shadow.row - 3 : 0);
    else        r = $urandom_range(tcw_pkg::ROWS - 1, 0);
    if (p % 10 == 0) c = $urandom_range(127, tcw_pkg::COLS);
    else             c = $urandom_range(tcw_pkg::COLS - 1, 0);
    return read_word(r, c);
  endfunction

  task automatic send_word(tcw_pkg::tcw_in_t w);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.note_word(w);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.pending() != 0);
  endtask

  initial begin
    tcw_pkg::tcw_in_t plan[$];
    shadow = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // cleared store, corners and out-of-range reads
    plan.push_back(read_word(0, 0));
    plan.push_back(read_word(tcw_pkg::ROWS - 1, tcw_pkg::COLS - 1));
    plan.push_back(read_word(tcw_pkg::ROWS - 1, tcw_pkg::COLS));
    plan.push_back(read_word(0, 127));
    // printable edges, control and high codes, zero, tabs, newline
    plan.push_back(put_word(8'h41));
    plan.push_back(put_word(8'h01));
    plan.push_back(put_word(8'h1F));
    plan.push_back(put_word(tcw_pkg::CH_SPACE));
    plan.push_back(put_word(tcw_pkg::CH_TILDE));
    plan.push_back(put_word(8'h7F));
    plan.push_back(put_word(tcw_pkg::CH_TAB));
    plan.push_back(put_word(tcw_pkg::CH_TAB));
    plan.push_back(put_word(8'h80));
    plan.push_back(put_word(8'hFF));
    plan.push_back(put_word(tcw_pkg::CH_NUL));
    plan.push_back(put_word(tcw_pkg::CH_NL));
    plan.push_back(put_word(tcw_pkg::CH_TAB));
    // read back what landed
    plan.push_back(read_word(0, 0));
    plan.push_back(read_word(0, 1));
    plan.push_back(read_word(0, 7));
    plan.push_back(read_word(0, 16));
    plan.push_back(read_word(0, 17));
    plan.push_back(read_word(1, 0));
    foreach (plan[i]) send_word(plan[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= 600 && i < 1000);
      if (i == 400 || i == 1300) hold_req = 1'b1;
      if (i == 1100) drain_results();
      send_word(($urandom_range(99) < 58) ? put_word(pick_char()) : random_read());
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("covered %0d puts (%0d tabs) and %0d reads, %0d store scrolls, in %0d cycles",
             shadow.puts, shadow.tabs, shadow.reads, shadow.scrolls, cycles);
    $display("%0d mismatches, %0d results outstanding", shadow.mismatches, shadow.pending());
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
